// ===== hw/rtl/tpc_pkg.sv =====
// tpc_pkg: shared types and constants for the tooth period checker
// used by tpc_div, tpc_scan and tooth_period_checker; no dependencies
package tpc_pkg;

  localparam int MAX_EDGES_DEF = 1024;
  localparam int WINDOW_DEF    = 8;

  // operation codes on the input tuser
  localparam logic [2:0] OP_ARM   = 3'd0;
  localparam logic [2:0] OP_EDGE  = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_CHECK = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_CHECK_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_SLOTS = 2'd1;
  localparam logic [1:0] CFG_TOL_LIMIT      = 2'd2;

  localparam int         QUO_W         = 26;
  localparam logic [QUO_W-1:0] SLOT_NUMERATOR = 26'd60000000;
  localparam logic [31:0] DEFAULT_TOL  = 32'd50;
  localparam int         EDGES_OUT_W   = 11;

  // window write controls from the capture logic
  typedef struct packed {
    logic clr;  // arm: pointer back to zero
    logic wr;   // write a delta at the pointer
    logic adv;  // edge recorded: advance the pointer
  } win_ctl_t;

  // one result word, first field in the highest bits
  typedef struct packed {
    logic [EDGES_OUT_W-1:0] edges_seen;
    logic [QUO_W-1:0]       expected_period;
    logic [31:0]            worst_measured;
    logic [31:0]            worst_deviation;
    logic                   error_flag;
    logic                   check_ran;
    logic                   accepted;
  } out_word_t;

endpackage

// ===== hw/rtl/tpc_div.sv =====
// tpc_div: bit-serial restoring divider, SLOT_NUMERATOR / divisor
// one quotient bit per cycle; depends on tpc_pkg
module tpc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [31:0]              divisor,
  output logic                     done,
  output logic [tpc_pkg::QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(tpc_pkg::QUO_W + 1);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [tpc_pkg::QUO_W-1:0] num_sh;
  logic [31:0]               rem;
  logic [31:0]               dvs;
  logic [32:0]               trial;

  // shift in the next numerator bit and try one subtract
  assign trial = {rem, num_sh[tpc_pkg::QUO_W-1]};
  assign done  = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CNT_W'(tpc_pkg::QUO_W);
      num_sh   <= tpc_pkg::SLOT_NUMERATOR;
      rem      <= '0;
      quotient <= '0;
      dvs      <= divisor;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt    <= cnt - 1'b1;
      num_sh <= {num_sh[tpc_pkg::QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem      <= 32'(trial - {1'b0, dvs});
        quotient <= {quotient[tpc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem      <= trial[31:0];
        quotient <= {quotient[tpc_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/tpc_scan.sv =====
// tpc_scan: ring of the last WINDOW edge deltas and the deviation scan
// one delta per cycle through a three-stage pipe; depends on tpc_pkg
module tpc_scan #(
  parameter int WINDOW = tpc_pkg::WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tpc_pkg::win_ctl_t         win_ctl,
  input  logic [31:0]               wr_data,
  input  logic                      start,
  input  logic [$clog2(WINDOW+1)-1:0] count,
  input  logic [tpc_pkg::QUO_W-1:0] period,
  output logic                      done,
  output logic [31:0]               worst_dev,
  output logic [31:0]               worst_meas
);

  localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  logic [31:0]   win [WINDOW];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] remain;
  logic          busy;
  logic [31:0]   per;
  logic          rd_v;
  logic [31:0]   rd_q;
  logic          ev_v;
  logic          ev_skip;
  logic [31:0]   ev_dt;
  logic [31:0]   ev_dev;
  logic [32:0]   diff;
  logic          skip;

  assign diff = {1'b0, rd_q} - {1'b0, per};
  // deltas above twice the period are sync gaps
  assign skip = {1'b0, rd_q} > {per, 1'b0};
  assign done = busy && (remain == '0) && !rd_v && !ev_v;

  always_ff @(posedge clk) begin
    if (win_ctl.wr) begin
      win[wptr] <= wr_data;
    end
    if (rst) begin
      wptr <= '0;
    end else if (win_ctl.clr) begin
      wptr <= '0;
    end else if (win_ctl.adv) begin
      wptr <= (wptr == PW'(WINDOW - 1)) ? '0 : wptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      remain <= '0;
      rd_v   <= 1'b0;
      ev_v   <= 1'b0;
    end else begin
      if (start) begin
        busy       <= 1'b1;
        remain     <= count;
        per        <= 32'(period);
        worst_dev  <= '0;
        worst_meas <= '0;
        // full window starts at the oldest entry, otherwise at entry one
        rptr <= (count == CW'(WINDOW)) ? wptr : PW'(1 % WINDOW);
      end else if (done) begin
        busy <= 1'b0;
      end
      rd_v <= busy && (remain != '0);
      if (busy && (remain != '0)) begin
        rd_q   <= win[rptr];
        rptr   <= (rptr == PW'(WINDOW - 1)) ? '0 : rptr + 1'b1;
        remain <= remain - 1'b1;
      end
      ev_v <= rd_v;
      if (rd_v) begin
        ev_dt   <= rd_q;
        ev_skip <= skip;
        ev_dev  <= diff[32] ? 32'(per - rd_q) : diff[31:0];
      end
      // strict compare keeps the first delta on ties
      if (ev_v && !ev_skip && (ev_dev > worst_dev)) begin
        worst_dev  <= ev_dev;
        worst_meas <= ev_dt;
      end
    end
  end

endmodule

// ===== hw/rtl/tooth_period_checker.sv =====
// tooth_period_checker: crank-wheel edge capture with a tooth-period check
// top level: capture state, sequencer, output register; uses tpc_pkg, tpc_div, tpc_scan
//
// Input words arrive on s_tvalid/s_tready. s_tuser carries the operation
// (arm, edge, stop, check, clear error), s_tdata the edge timestamp and rpm.
// Every input word gives exactly one result word on m_tvalid/m_tready.
// Configuration is written on cfg_we/cfg_index/cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce. Arm, edge,
// stop, clear, spare codes and checks refused for enable, rpm or slots go from accept
// through S_PUSH into the output register. A check that forms the period goes
// through the rpm * slots product and the bit-serial divider, then, unless the
// quotient is zero or no delta has been captured since arm, through the delta scan
// pipe, which looks at up to WINDOW deltas. One word is worked on at a time;
// s_tready is high while the sequencer is free, also while a finished result waits
// in the output register. If the receiver stalls, the result holds in m_tdata and
// one more finished result waits inside until the output register frees.
// Reset clears capture, edge count, sticky error and config to defaults;
// the delta ring is not cleared, a check only reads deltas since the last arm.
module tooth_period_checker #(
  parameter int MAX_EDGES = tpc_pkg::MAX_EDGES_DEF,
  parameter int WINDOW    = tpc_pkg::WINDOW_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [47:0]   s_tdata,   // edge_time[31:0], rpm[47:32]
  input  logic [2:0]    s_tuser,   // operation[2:0]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // accepted[0], check_ran[1], error_flag[2],
                                   // worst_deviation[34:3], worst_measured[66:35],
                                   // expected_period[92:67], edges_seen[103:93]
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int CW  = $clog2(WINDOW + 1);
  localparam int SW  = (ECW > tpc_pkg::EDGES_OUT_W) ? ECW : tpc_pkg::EDGES_OUT_W;
  localparam int NW  = (ECW > CW) ? ECW : CW;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_SCAN, S_PUSH} state_t;

  state_t              state;
  logic                check_enable;
  logic [15:0]         expected_slots;
  logic [31:0]         tol_limit;
  logic                capture_armed;
  logic [ECW-1:0]      edge_count;
  logic [31:0]         previous_time;
  logic                sticky_error;
  logic [31:0]         prod;
  tpc_pkg::out_word_t  res;
  tpc_pkg::out_word_t  res_next;

  logic                in_acc;
  logic [2:0]          op;
  logic [31:0]         edge_time;
  logic [15:0]         rpm;
  tpc_pkg::win_ctl_t   win_ctl;
  logic                edge_full;
  logic                check_go;
  logic                div_start;
  logic                div_done;
  logic [tpc_pkg::QUO_W-1:0] div_q;
  logic                scan_start;
  logic                scan_done;
  logic [31:0]         worst_dev;
  logic [31:0]         worst_meas;
  logic [NW-1:0]       ec_m1;
  logic [CW-1:0]       scan_count;
  logic [31:0]         tol;
  logic [SW-1:0]       ec_ext;
  logic [tpc_pkg::EDGES_OUT_W-1:0] edges_now;
  logic                few_edges;

  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign op        = s_tuser;
  assign edge_time = s_tdata[31:0];
  assign rpm       = s_tdata[47:32];

  assign edge_full   = (edge_count >= ECW'(MAX_EDGES));
  assign win_ctl.clr = in_acc && (op == tpc_pkg::OP_ARM) && !capture_armed;
  assign win_ctl.adv = in_acc && (op == tpc_pkg::OP_EDGE) && capture_armed && !edge_full;
  assign win_ctl.wr  = win_ctl.adv && (edge_count != '0);

  assign ec_ext    = SW'(edge_count);
  assign edges_now = ec_ext[tpc_pkg::EDGES_OUT_W-1:0];
  assign few_edges = (edge_count < ECW'(2));

  // deltas available since arm: edge_count - 1, capped at the window size
  assign ec_m1      = NW'(edge_count) - 1'b1;
  assign scan_count = (ec_m1 >= NW'(WINDOW)) ? CW'(WINDOW) : CW'(ec_m1);

  assign check_go   = (op == tpc_pkg::OP_CHECK) && check_enable && (rpm != '0) &&
                      (expected_slots != '0);
  assign div_start  = (state == S_MUL);
  assign scan_start = (state == S_DIV) && div_done && (div_q != '0) && !few_edges;
  assign tol        = (tol_limit != '0) ? tol_limit : tpc_pkg::DEFAULT_TOL;

  // result fields known at accept time
  always_comb begin
    res_next            = '0;
    res_next.accepted   = 1'b1;
    res_next.error_flag = sticky_error;
    res_next.edges_seen = edges_now;
    case (op)
      tpc_pkg::OP_ARM: begin
        if (capture_armed) begin
          res_next.accepted = 1'b0;
        end else begin
          res_next.edges_seen = '0;
        end
      end
      tpc_pkg::OP_EDGE: begin
        if (capture_armed && !edge_full) begin
          res_next.edges_seen = edges_now + 1'b1;
        end
      end
      tpc_pkg::OP_CLEAR: begin
        res_next.error_flag = 1'b0;
      end
      default: ;
    endcase
  end

  tpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (prod),
    .done     (div_done),
    .quotient (div_q)
  );

  tpc_scan #(
    .WINDOW (WINDOW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .win_ctl    (win_ctl),
    .wr_data    (edge_time - previous_time),
    .start      (scan_start),
    .count      (scan_count),
    .period     (div_q),
    .done       (scan_done),
    .worst_dev  (worst_dev),
    .worst_meas (worst_meas)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      check_enable   <= 1'b0;
      expected_slots <= '0;
      tol_limit      <= tpc_pkg::DEFAULT_TOL;
      capture_armed  <= 1'b0;
      edge_count     <= '0;
      previous_time  <= '0;
      sticky_error   <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tpc_pkg::CFG_CHECK_ENABLE:   check_enable   <= cfg_data[0];
          tpc_pkg::CFG_EXPECTED_SLOTS: expected_slots <= cfg_data[15:0];
          tpc_pkg::CFG_TOL_LIMIT:      tol_limit      <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && (state != S_PUSH)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            res   <= res_next;
            state <= check_go ? S_MUL : S_PUSH;
            case (op)
              tpc_pkg::OP_ARM: begin
                if (!capture_armed) begin
                  capture_armed <= 1'b1;
                  edge_count    <= '0;
                end
              end
              tpc_pkg::OP_EDGE: begin
                if (capture_armed) begin
                  if (edge_full) begin
                    capture_armed <= 1'b0;
                  end else begin
                    previous_time <= edge_time;
                    edge_count    <= edge_count + 1'b1;
                  end
                end
              end
              tpc_pkg::OP_STOP: begin
                capture_armed <= 1'b0;
              end
              tpc_pkg::OP_CHECK: begin
                if (check_go) begin
                  prod <= 32'(rpm * expected_slots);
                end
              end
              tpc_pkg::OP_CLEAR: begin
                sticky_error <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res.expected_period <= div_q;
            state               <= scan_start ? S_SCAN : S_PUSH;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            res.check_ran       <= 1'b1;
            res.worst_deviation <= worst_dev;
            res.worst_measured  <= worst_meas;
            if (worst_dev > tol) begin
              sticky_error   <= 1'b1;
              res.error_flag <= 1'b1;
            end
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the sticky error is only ever set at the end of a delta scan
  a_err_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(sticky_error) |-> $past(scan_done))
    else $error("sticky error set outside a scan");

  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    edge_count <= ECW'(MAX_EDGES))
    else $error("edge count beyond capacity");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

  // a check that ran always reports a nonzero period
  a_ran_period: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> (m_tdata[92:67] != '0))
    else $error("check ran with zero period");

endmodule

// ===== dv/tooth_period_checker_test.sv =====
// tooth_period_checker_test: self-checking bench for the tooth period checker
// drives arm/edge/stop/check/clear and spare-code words, predicts every result word in-bench
// and compares field by field; depends on tpc_pkg and tooth_period_checker
module tooth_period_checker_test;

  localparam int EDGE_LIMIT   = tpc_pkg::MAX_EDGES_DEF;
  localparam int WINDOW_LEN   = tpc_pkg::WINDOW_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int QUIET_CYCLES = 60;
  localparam int HOLD_LEN     = 400;
  localparam int MAX_PRINTS   = 30;
  localparam longint unsigned PERIOD_NUM = 60000000;
  localparam logic [31:0] TOL_FALLBACK = 32'd50;

  // codes the block ignores
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] stamp;
    logic [15:0] rpm;
  } capture_word_t;

  logic         clk;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata   = '0;  // edge_time[31:0], rpm[47:32]
  logic [2:0]   s_tuser   = '0;  // operation[2:0]
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [103:0] m_tdata;         // accepted, check_ran, error_flag, worst_deviation,
                                 // worst_measured, expected_period, edges_seen
  logic         cfg_we    = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data  = '0;

  tooth_period_checker dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted block state and register copy
  logic        cap_armed  = 1'b0;
  int          edge_cnt   = 0;
  logic [31:0] prev_stamp = '0;
  logic [31:0] delta_ring [WINDOW_LEN];
  logic        sticky_err = 1'b0;
  logic        cfg_enable = 1'b0;
  logic [15:0] cfg_slots  = '0;
  logic [31:0] cfg_tol    = TOL_FALLBACK;

  capture_word_t      capture_words_pending [$];
  tpc_pkg::out_word_t capture_results_due [$];
  capture_word_t      in_flight;
  tpc_pkg::out_word_t got_word, due_word;

  int words_queued    = 0;
  int words_accepted  = 0;
  int results_checked = 0;
  int checks_run      = 0;
  int refused_arms    = 0;
  int error_results   = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  logic hold_on       = 1'b0;
  int hold_cycles     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tpc_pkg::out_word_t compute_capture_result(capture_word_t w);
    tpc_pkg::out_word_t r;
    longint unsigned    quo, prod;
    logic [31:0]        p, dt, dev, tol_eff;
    int                 first, i;
    r = '0;
    r.accepted = 1'b1;
    quo = 0;
    case (w.op)
      tpc_pkg::OP_ARM: begin
        if (cap_armed) begin
          r.accepted = 1'b0;
        end else begin
          edge_cnt = 0;
          cap_armed = 1'b1;
        end
      end
      tpc_pkg::OP_EDGE: begin
        if (cap_armed) begin
          // a full capture disarms on the next edge without recording it
          if (edge_cnt >= EDGE_LIMIT) begin
            cap_armed = 1'b0;
          end else begin
            if (edge_cnt >= 1) delta_ring[edge_cnt % WINDOW_LEN] = w.stamp - prev_stamp;
            prev_stamp = w.stamp;
            edge_cnt++;
          end
        end
      end
      tpc_pkg::OP_STOP: cap_armed = 1'b0;
      tpc_pkg::OP_CHECK: begin
        if (cfg_enable && w.rpm != 0 && cfg_slots != 0) begin
          prod = 64'(w.rpm);
          prod = prod * 64'(cfg_slots);
          quo = PERIOD_NUM / prod;
          if (quo != 0 && edge_cnt >= 2) begin
            first = (edge_cnt > WINDOW_LEN) ? edge_cnt - WINDOW_LEN : 1;
            tol_eff = (cfg_tol == 0) ? TOL_FALLBACK : cfg_tol;
            p = quo[31:0];
            r.check_ran = 1'b1;
            for (i = first; i < edge_cnt; i++) begin
              dt = delta_ring[i % WINDOW_LEN];
              // deltas over twice the period are sync gaps
              if ({32'd0, dt} <= quo * 2) begin
                dev = (dt > p) ? dt - p : p - dt;
                if (dev > r.worst_deviation) begin
                  r.worst_deviation = dev;
                  r.worst_measured = dt;
                end
              end
            end
            if (r.worst_deviation > tol_eff) sticky_err = 1'b1;
          end
        end
      end
      tpc_pkg::OP_CLEAR: sticky_err = 1'b0;
      default: ;
    endcase
    r.error_flag = sticky_err;
    r.expected_period = quo[tpc_pkg::QUO_W-1:0];
    r.edges_seen = edge_cnt[tpc_pkg::EDGES_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch at result %0d: %s got %0h want %0h", results_checked, what, got, want);
    mismatch_count++;
  endtask

  // driver: one word in flight, held until accepted
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        capture_results_due.push_back(compute_capture_result(in_flight));
        words_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (capture_words_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_flight = capture_words_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= in_flight.op;
          s_tdata <= {in_flight.rpm, in_flight.stamp};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_word = m_tdata;
        if (capture_results_due.size() == 0) begin
          report_mismatch("word with nothing due", 32'd0, 32'd0);
        end else begin
          due_word = capture_results_due.pop_front();
          if (got_word.accepted !== due_word.accepted)
            report_mismatch("accepted", 32'(got_word.accepted), 32'(due_word.accepted));
          if (got_word.check_ran !== due_word.check_ran)
            report_mismatch("check_ran", 32'(got_word.check_ran), 32'(due_word.check_ran));
          if (got_word.error_flag !== due_word.error_flag)
            report_mismatch("error_flag", 32'(got_word.error_flag),
                            32'(due_word.error_flag));
          if (got_word.worst_deviation !== due_word.worst_deviation)
            report_mismatch("worst_deviation", got_word.worst_deviation,
                            due_word.worst_deviation);
          if (got_word.worst_measured !== due_word.worst_measured)
            report_mismatch("worst_measured", got_word.worst_measured,
                            due_word.worst_measured);
          if (got_word.expected_period !== due_word.expected_period)
            report_mismatch("expected_period", 32'(got_word.expected_period),
                            32'(due_word.expected_period));
          if (got_word.edges_seen !== due_word.edges_seen)
            report_mismatch("edges_seen", 32'(got_word.edges_seen),
                            32'(due_word.edges_seen));
          if (due_word.check_ran) checks_run++;
          if (!due_word.accepted) refused_arms++;
          if (due_word.error_flag) error_results++;
        end
        results_checked++;
      end
      m_tready <= !(hold_on && hold_cycles < HOLD_LEN) &&
                  ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, counted once
  always @(posedge clk) begin
    if (hold_on && hold_cycles < HOLD_LEN) hold_cycles <= hold_cycles + 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void push_item(input logic [2:0] op, input logic [31:0] stamp,
                                    input logic [15:0] rpm);
    capture_word_t w;
    w.op = op;
    w.stamp = stamp;
    w.rpm = rpm;
    capture_words_pending.push_back(w);
    words_queued++;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      tpc_pkg::CFG_CHECK_ENABLE:   cfg_enable = val[0];
      tpc_pkg::CFG_EXPECTED_SLOTS: cfg_slots = val[15:0];
      tpc_pkg::CFG_TOL_LIMIT:      cfg_tol = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic en, input logic [15:0] slots, input logic [31:0] tol);
    write_reg(tpc_pkg::CFG_CHECK_ENABLE, {31'd0, en});
    write_reg(tpc_pkg::CFG_EXPECTED_SLOTS, {16'd0, slots});
    write_reg(tpc_pkg::CFG_TOL_LIMIT, tol);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (words_accepted != words_queued || capture_results_due.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // optional stop, arm, edges mostly around the expected period, then checks, optional clear/stop
  task automatic add_capture_run(output int added);
    int          n, k;
    logic [15:0] rpm;
    int unsigned max_rpm, per, jit, tol_eff, delta;
    logic [31:0] t;
    added = 0;
    if (cfg_slots == 0) begin
      rpm = 16'($urandom_range(1, 65535));
      per = 1000;
    end else begin
      max_rpm = 60000000 / cfg_slots;
      if (max_rpm > 65535) max_rpm = 65535;
      if ($urandom_range(0, 2) != 0 && max_rpm > 8000) max_rpm = 8000;
      rpm = 16'($urandom_range(1, max_rpm));
      per = 60000000 / (rpm * cfg_slots);
    end
    tol_eff = (cfg_tol == 0) ? 50 : cfg_tol;
    jit = (tol_eff > per / 2) ? per : 2 * tol_eff;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
    if ($urandom_range(0, 1)) begin
      push_item(tpc_pkg::OP_STOP, $urandom, 16'($urandom_range(0, 65535)));
      added++;
    end
    push_item(tpc_pkg::OP_ARM, $urandom, 16'($urandom_range(0, 65535)));
    added++;
    t = $urandom;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0, 1:    delta = 2 * per + 1 + $urandom_range(0, per);
        2:       delta = $urandom;
        default: delta = per - jit + $urandom_range(0, 2 * jit);
      endcase
      t = t + delta;
      push_item(tpc_pkg::OP_EDGE, t, 16'($urandom_range(0, 65535)));
      added++;
      if ($urandom_range(0, 15) == 0) begin
        push_item(tpc_pkg::OP_CHECK, $urandom, rpm);
        added++;
      end
    end
    push_item(tpc_pkg::OP_CHECK, $urandom, rpm);
    added++;
    if ($urandom_range(0, 3) == 0) begin
      push_item(tpc_pkg::OP_CHECK, $urandom, 16'($urandom_range(0, 65535)));
      added++;
    end
    if ($urandom_range(0, 2) == 0) begin
      push_item(tpc_pkg::OP_CLEAR, $urandom, 16'($urandom_range(0, 65535)));
      added++;
    end
    if ($urandom_range(0, 2) == 0) begin
      push_item(tpc_pkg::OP_STOP, $urandom, 16'($urandom_range(0, 65535)));
      added++;
    end
  endtask

  task automatic add_random(input int count);
    int added, got, k, n;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 4) != 0) begin
        add_capture_run(got);
        added += got;
      end else begin
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++)
          push_item(3'($urandom_range(0, 7)), $urandom, 16'($urandom_range(0, 65535)));
        added += n;
      end
    end
  endtask

  task automatic run_phase(input logic en, input logic [15:0] slots, input logic [31:0] tol,
                           input int send_pct, input int recv_pct, input int count);
    configure(en, slots, tol);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
    add_random(count);
    wait_idle();
  endtask

  initial begin : stimulus
    int          k;
    logic [31:0] t;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset config: checks disabled, capture basics, wrapped delta, ignored codes
    push_item(tpc_pkg::OP_ARM, 32'd0, 16'd0);
    push_item(tpc_pkg::OP_ARM, 32'd0, 16'd0);
    push_item(tpc_pkg::OP_EDGE, 32'hFFFF_FFF0, 16'hFFFF);
    push_item(tpc_pkg::OP_EDGE, 32'h0000_0010, 16'd0);
    push_item(tpc_pkg::OP_CHECK, 32'd0, 16'd1000);
    push_item(tpc_pkg::OP_STOP, 32'd0, 16'd0);
    push_item(tpc_pkg::OP_STOP, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(tpc_pkg::OP_EDGE, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(OP_SPARE_A, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(OP_SPARE_B, 32'd0, 16'd0);
    push_item(OP_SPARE_C, 32'hA5A5_5A5A, 16'h5A5A);
    push_item(tpc_pkg::OP_CLEAR, 32'd0, 16'd0);
    wait_idle();

    // 60 slots, tolerance falls back to 50
    configure(1'b1, 16'd60, 32'd0);
    push_item(tpc_pkg::OP_CHECK, 32'd0, 16'd0);
    push_item(tpc_pkg::OP_CHECK, 32'd0, 16'd1000);
    push_item(tpc_pkg::OP_CLEAR, 32'd0, 16'd0);
    push_item(tpc_pkg::OP_ARM, 32'd0, 16'd0);
    push_item(tpc_pkg::OP_EDGE, 32'd1000, 16'd0);
    push_item(tpc_pkg::OP_CHECK, 32'd0, 16'd1000);
    push_item(tpc_pkg::OP_EDGE, 32'd2030, 16'd0);
    push_item(tpc_pkg::OP_EDGE, 32'd3000, 16'd0);
    // equal deviations either side: the first one wins
    push_item(tpc_pkg::OP_CHECK, 32'd0, 16'd1000);
    push_item(tpc_pkg::OP_EDGE, 32'd6000, 16'd0);
    push_item(tpc_pkg::OP_CHECK, 32'd0, 16'd1000);
    // period 15: every delta is a sync gap
    push_item(tpc_pkg::OP_CHECK, 32'd0, 16'hFFFF);
    push_item(tpc_pkg::OP_STOP, 32'd0, 16'd0);
    wait_idle();

    hold_on <= 1'b1;
    run_phase(1'b1, 16'd60, 32'd0, 0, 0, 50);
    run_phase(1'b1, 16'd36, 32'd1, 79, 0, 40);
    run_phase(1'b1, 16'd1, 32'hFFFF_FFFF, 0, 79, 40);
    run_phase(1'b1, 16'hFFFF, $urandom_range(0, 400), 15, 15, 35);
    run_phase(1'b0, 16'd60, 32'd20, 15, 15, 20);
    run_phase(1'b1, 16'd0, 32'd100, 0, 0, 15);
    run_phase(1'b1, 16'd60, 32'd50, 15, 15, 25);

    // full capture: the edge after the limit disarms, the next is ignored
    configure(1'b1, 16'd60, 32'd200);
    send_idle_pct <= 0;
    recv_stall_pct <= 15;
    push_item(tpc_pkg::OP_STOP, 32'd0, 16'd0);
    push_item(tpc_pkg::OP_ARM, 32'd0, 16'd0);
    t = $urandom;
    for (k = 0; k < EDGE_LIMIT + 2; k++) begin
      t = t + (($urandom_range(0, 31) == 0) ? 32'd2500 : 32'd850 + $urandom_range(0, 300));
      push_item(tpc_pkg::OP_EDGE, t, 16'($urandom_range(0, 65535)));
    end
    push_item(tpc_pkg::OP_CHECK, 32'd0, 16'd1000);
    push_item(tpc_pkg::OP_ARM, 32'd0, 16'd0);
    push_item(tpc_pkg::OP_STOP, 32'd0, 16'd0);
    wait_idle();

    if (capture_results_due.size() != 0)
      report_mismatch("results never seen", capture_results_due.size(), 32'd0);
    $display("summary: %0d words driven, %0d results compared, %0d checks ran",
             words_accepted, results_checked, checks_run);
    $display("summary: %0d arms refused, %0d results with error set, %0d mismatches",
             refused_arms, error_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_div.sv
hw/rtl/tpc_scan.sv
hw/rtl/tooth_period_checker.sv
dv/tooth_period_checker_test.sv
